// File: hw/rtl/dtc_pkg.sv
package dtc_pkg;

    localparam int BLK_W = 64;
    localparam int HALF_W = 32;
    localparam int KEY_W = 64;
    localparam int CD_W = 28;
    localparam int SUB_W = 48;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_KEY_ONE   = 3'd0,
        CFG_KEY_TWO   = 3'd1,
        CFG_KEY_THREE = 3'd2,
        CFG_DIRECTION = 3'd3,
        CFG_KEY_MODE  = 3'd4,
        CFG_CHAINING  = 3'd5,
        CFG_IV        = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        KM_SINGLE = 2'd0,
        KM_TWO    = 2'd1,
        KM_THREE  = 2'd2
    } t_key_mode;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       finish;
        logic [3:0] round;
        logic [1:0] stage;
    } t_dp_cmd;

    typedef struct packed {
        logic last_stage;
    } t_dp_status;

    localparam byte unsigned IP_TAB [64] = '{
        58, 50, 42, 34, 26, 18, 10, 2, 60, 52, 44, 36, 28, 20, 12, 4,
        62, 54, 46, 38, 30, 22, 14, 6, 64, 56, 48, 40, 32, 24, 16, 8,
        57, 49, 41, 33, 25, 17, 9, 1, 59, 51, 43, 35, 27, 19, 11, 3,
        61, 53, 45, 37, 29, 21, 13, 5, 63, 55, 47, 39, 31, 23, 15, 7};

    localparam byte unsigned FP_TAB [64] = '{
        40, 8, 48, 16, 56, 24, 64, 32, 39, 7, 47, 15, 55, 23, 63, 31,
        38, 6, 46, 14, 54, 22, 62, 30, 37, 5, 45, 13, 53, 21, 61, 29,
        36, 4, 44, 12, 52, 20, 60, 28, 35, 3, 43, 11, 51, 19, 59, 27,
        34, 2, 42, 10, 50, 18, 58, 26, 33, 1, 41, 9, 49, 17, 57, 25};

    localparam byte unsigned E_TAB [48] = '{
        32, 1, 2, 3, 4, 5, 4, 5, 6, 7, 8, 9, 8, 9, 10, 11,
        12, 13, 12, 13, 14, 15, 16, 17, 16, 17, 18, 19, 20, 21, 20, 21,
        22, 23, 24, 25, 24, 25, 26, 27, 28, 29, 28, 29, 30, 31, 32, 1};

    localparam byte unsigned P_TAB [32] = '{
        16, 7, 20, 21, 29, 12, 28, 17, 1, 15, 23, 26, 5, 18, 31, 10,
        2, 8, 24, 14, 32, 27, 3, 9, 19, 13, 30, 6, 22, 11, 4, 25};

    localparam byte unsigned PC1_TAB [56] = '{
        57, 49, 41, 33, 25, 17, 9, 1, 58, 50, 42, 34, 26, 18,
        10, 2, 59, 51, 43, 35, 27, 19, 11, 3, 60, 52, 44, 36,
        63, 55, 47, 39, 31, 23, 15, 7, 62, 54, 46, 38, 30, 22,
        14, 6, 61, 53, 45, 37, 29, 21, 13, 5, 28, 20, 12, 4};

    localparam byte unsigned PC2_TAB [48] = '{
        14, 17, 11, 24, 1, 5, 3, 28, 15, 6, 21, 10,
        23, 19, 12, 4, 26, 8, 16, 7, 27, 20, 13, 2,
        41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
        44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32};

    // Rows of sixteen; entry index is {row, column}.
    localparam logic [3:0] SBOX [8][64] = '{
        '{14, 4, 13, 1, 2, 15, 11, 8, 3, 10, 6, 12, 5, 9, 0, 7,
          0, 15, 7, 4, 14, 2, 13, 1, 10, 6, 12, 11, 9, 5, 3, 8,
          4, 1, 14, 8, 13, 6, 2, 11, 15, 12, 9, 7, 3, 10, 5, 0,
          15, 12, 8, 2, 4, 9, 1, 7, 5, 11, 3, 14, 10, 0, 6, 13},
        '{15, 1, 8, 14, 6, 11, 3, 4, 9, 7, 2, 13, 12, 0, 5, 10,
          3, 13, 4, 7, 15, 2, 8, 14, 12, 0, 1, 10, 6, 9, 11, 5,
          0, 14, 7, 11, 10, 4, 13, 1, 5, 8, 12, 6, 9, 3, 2, 15,
          13, 8, 10, 1, 3, 15, 4, 2, 11, 6, 7, 12, 0, 5, 14, 9},
        '{10, 0, 9, 14, 6, 3, 15, 5, 1, 13, 12, 7, 11, 4, 2, 8,
          13, 7, 0, 9, 3, 4, 6, 10, 2, 8, 5, 14, 12, 11, 15, 1,
          13, 6, 4, 9, 8, 15, 3, 0, 11, 1, 2, 12, 5, 10, 14, 7,
          1, 10, 13, 0, 6, 9, 8, 7, 4, 15, 14, 3, 11, 5, 2, 12},
        '{7, 13, 14, 3, 0, 6, 9, 10, 1, 2, 8, 5, 11, 12, 4, 15,
          13, 8, 11, 5, 6, 15, 0, 3, 4, 7, 2, 12, 1, 10, 14, 9,
          10, 6, 9, 0, 12, 11, 7, 13, 15, 1, 3, 14, 5, 2, 8, 4,
          3, 15, 0, 6, 10, 1, 13, 8, 9, 4, 5, 11, 12, 7, 2, 14},
        '{2, 12, 4, 1, 7, 10, 11, 6, 8, 5, 3, 15, 13, 0, 14, 9,
          14, 11, 2, 12, 4, 7, 13, 1, 5, 0, 15, 10, 3, 9, 8, 6,
          4, 2, 1, 11, 10, 13, 7, 8, 15, 9, 12, 5, 6, 3, 0, 14,
          11, 8, 12, 7, 1, 14, 2, 13, 6, 15, 0, 9, 10, 4, 5, 3},
        '{12, 1, 10, 15, 9, 2, 6, 8, 0, 13, 3, 4, 14, 7, 5, 11,
          10, 15, 4, 2, 7, 12, 9, 5, 6, 1, 13, 14, 0, 11, 3, 8,
          9, 14, 15, 5, 2, 8, 12, 3, 7, 0, 4, 10, 1, 13, 11, 6,
          4, 3, 2, 12, 9, 5, 15, 10, 11, 14, 1, 7, 6, 0, 8, 13},
        '{4, 11, 2, 14, 15, 0, 8, 13, 3, 12, 9, 7, 5, 10, 6, 1,
          13, 0, 11, 7, 4, 9, 1, 10, 14, 3, 5, 12, 2, 15, 8, 6,
          1, 4, 11, 13, 12, 3, 7, 14, 10, 15, 6, 8, 0, 5, 9, 2,
          6, 11, 13, 8, 1, 4, 10, 7, 9, 5, 0, 15, 14, 2, 3, 12},
        '{13, 2, 8, 4, 6, 15, 11, 1, 10, 9, 3, 14, 5, 0, 12, 7,
          1, 15, 13, 8, 10, 3, 7, 4, 12, 5, 6, 11, 0, 14, 9, 2,
          7, 11, 4, 1, 9, 12, 14, 2, 0, 6, 10, 13, 15, 3, 5, 8,
          2, 1, 14, 7, 4, 10, 8, 13, 15, 12, 9, 0, 3, 5, 6, 11}};

    // Tables number bits from 1 at the most significant end.
    function automatic logic [63:0] f_ip(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[6'(64 - int'(IP_TAB[i]))];
        return y;
    endfunction

    function automatic logic [63:0] f_fp(input logic [63:0] x);
        logic [63:0] y;
        for (int i = 0; i < 64; i++) y[63-i] = x[6'(64 - int'(FP_TAB[i]))];
        return y;
    endfunction

    function automatic logic [55:0] f_pc1(input logic [63:0] x);
        logic [55:0] y;
        for (int i = 0; i < 56; i++) y[55-i] = x[6'(64 - int'(PC1_TAB[i]))];
        return y;
    endfunction

    function automatic logic [47:0] f_pc2(input logic [55:0] x);
        logic [47:0] y;
        for (int i = 0; i < 48; i++) y[47-i] = x[6'(56 - int'(PC2_TAB[i]))];
        return y;
    endfunction

    function automatic logic [31:0] f_feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] y;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) e[47-i] = r[5'(32 - int'(E_TAB[i]))];
        e = e ^ k;
        for (int i = 0; i < 8; i++) begin
            six = e[47-6*i -: 6];
            s[31-4*i -: 4] = SBOX[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) y[31-i] = s[5'(32 - int'(P_TAB[i]))];
        return y;
    endfunction

endpackage

// File: hw/rtl/des_tdes_cbc_cipher.sv
// Each accepted block runs its Feistel rounds for one DES stage or three and lands in
// the output register; the last round waits while a previous result is stalled, and no
// new item is taken until it lands. One Feistel round per cycle outside that wait, with
// the subkey rotated out of the key registers in the same cycle as its round.
// Reset (synchronous, active low) clears the key registers, the chain value and the
// handshakes; no clearing pass is needed.
module des_tdes_cbc_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [63:0] data_block
    input  logic        s_axis_tuser,   // [0] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [63:0] result_block
);
    import dtc_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    dtc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dtc_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_data_block   (s_axis_tdata),
        .i_restart      (s_axis_tuser),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_result_block (m_axis_tdata)
    );

endmodule

// File: hw/rtl/dtc_ctrl.sv
module dtc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  dtc_pkg::t_dp_status i_status,
    output dtc_pkg::t_dp_cmd    o_cmd
);
    import dtc_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_round, n_round;
    logic [1:0] r_stage, n_stage;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_round     <= '0;
            r_stage     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_round     <= n_round;
            r_stage     <= n_stage;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_round     = r_round;
        n_stage     = r_stage;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.round = r_round;
        o_cmd.stage = r_stage;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_round    = '0;
                    n_stage    = '0;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_round != 4'd15 || !i_status.last_stage) begin
                    o_cmd.step = 1'b1;
                    n_round    = r_round + 4'd1;
                    if (r_round == 4'd15) n_stage = r_stage + 2'd1;
                end else if (!r_out_valid || i_out_ready) begin
                    // The last round lands straight in the output register.
                    o_cmd.step   = 1'b1;
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hw/rtl/dtc_datapath.sv
module dtc_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [63:0]         i_cfg_wdata,
    input  logic [63:0]         i_data_block,
    input  logic                i_restart,
    input  dtc_pkg::t_dp_cmd    i_cmd,
    output dtc_pkg::t_dp_status o_status,
    output logic [63:0]         o_result_block
);
    import dtc_pkg::*;

    logic [KEY_W-1:0]  r_key_one, r_key_two, r_key_three, r_iv;
    logic              r_dir, r_chaining;
    logic [1:0]        r_key_mode;
    logic [BLK_W-1:0]  r_chain, r_blk, r_result;
    logic [HALF_W-1:0] r_l, r_r;
    logic [CD_W-1:0]   r_c, r_d;

    logic [BLK_W-1:0]  w_chain, w_in, w_ip, w_fp;
    logic [HALF_W-1:0] w_rn;
    logic [CD_W-1:0]   w_c, w_d;
    logic [SUB_W-1:0]  w_k;
    logic [55:0]       w_cd_next;
    logic              w_single, w_dec, w_one, w_zero;
    logic [1:0]        w_next_stage;

    // Key of a triple DES stage; the stages run E-D-E to encrypt, D-E-D to decrypt.
    function automatic logic [63:0] f_stage_key(input logic [1:0] stage);
        logic [63:0] last;
        last = (t_key_mode'(r_key_mode) == KM_TWO) ? r_key_one : r_key_three;
        if (stage == 2'd1) return r_key_two;
        if ((stage == 2'd0) != r_dir) return r_key_one;
        return (t_key_mode'(r_key_mode) == KM_SINGLE) ? r_key_one : last;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_one   <= '0;
            r_key_two   <= '0;
            r_key_three <= '0;
            r_iv        <= '0;
            r_dir       <= 1'b0;
            r_key_mode  <= '0;
            r_chaining  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_ONE:   r_key_one   <= i_cfg_wdata;
                CFG_KEY_TWO:   r_key_two   <= i_cfg_wdata;
                CFG_KEY_THREE: r_key_three <= i_cfg_wdata;
                CFG_DIRECTION: r_dir       <= i_cfg_wdata[0];
                CFG_KEY_MODE:  r_key_mode  <= i_cfg_wdata[1:0];
                CFG_CHAINING:  r_chaining  <= i_cfg_wdata[0];
                CFG_IV:        r_iv        <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_single          = (t_key_mode'(r_key_mode) == KM_SINGLE);
    assign o_status.last_stage = w_single || (i_cmd.stage == 2'd2);
    assign w_dec             = r_dir ^ (i_cmd.stage == 2'd1);
    assign w_next_stage      = i_cmd.stage + 2'd1;

    assign w_chain = i_restart ? r_iv : r_chain;
    assign w_in    = (r_chaining && !r_dir) ? (i_data_block ^ w_chain) : i_data_block;
    assign w_ip    = f_ip(w_in);

    // Single shifts on rounds one, two, nine and sixteen; decryption rotates the other
    // way and leaves the first round unshifted.
    assign w_one  = (i_cmd.round == 4'd0) || (i_cmd.round == 4'd1) ||
                    (i_cmd.round == 4'd8) || (i_cmd.round == 4'd15);
    assign w_zero = w_dec && (i_cmd.round == 4'd0);

    always_comb begin
        if (w_zero) begin
            w_c = r_c;
            w_d = r_d;
        end else if (!w_dec) begin
            w_c = w_one ? {r_c[26:0], r_c[27]} : {r_c[25:0], r_c[27:26]};
            w_d = w_one ? {r_d[26:0], r_d[27]} : {r_d[25:0], r_d[27:26]};
        end else begin
            w_c = (w_one && i_cmd.round != 4'd0) ? {r_c[0], r_c[27:1]} : {r_c[1:0], r_c[27:2]};
            w_d = (w_one && i_cmd.round != 4'd0) ? {r_d[0], r_d[27:1]} : {r_d[1:0], r_d[27:2]};
        end
    end

    assign w_k       = f_pc2({w_c, w_d});
    assign w_rn      = r_l ^ f_feistel(r_r, w_k);
    assign w_fp      = f_fp({w_rn, r_r});
    assign w_cd_next = f_pc1(f_stage_key(w_next_stage));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.load) begin
            r_chain <= w_chain;
        end else if (i_cmd.finish && r_chaining) begin
            r_chain <= r_dir ? r_blk : w_fp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blk <= i_data_block;
            r_l   <= w_ip[63:32];
            r_r   <= w_ip[31:0];
            {r_c, r_d} <= f_pc1(f_stage_key(2'd0));
        end else if (i_cmd.step) begin
            if (i_cmd.round == 4'd15) begin
                // The pre-output swap carries straight into the next stage.
                r_l <= w_rn;
                r_r <= r_r;
                {r_c, r_d} <= w_cd_next;
            end else begin
                r_l <= r_r;
                r_r <= w_rn;
                r_c <= w_c;
                r_d <= w_d;
            end
        end
        if (i_cmd.finish) begin
            r_result <= (r_chaining && r_dir) ? (w_fp ^ r_chain) : w_fp;
        end
    end

    assign o_result_block = r_result;

endmodule

// File: hw/rtl/dtc_checker.sv
module dtc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while the rounds were still running");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !$rose(m_axis_tvalid))
        else $error("result appeared in the cycle after accepting an item");

    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind des_tdes_cbc_cipher dtc_checker u_dtc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
